FILE: rtl/core/itsu_pkg.sv
// Shared constants, widths and the arctangent table of the inverse trig unit.
package itsu_pkg;

   localparam int ITERATIONS    = 28;
   localparam int ARG_FRAC_BITS = 16;

   localparam int ARG_W      = 32;
   localparam int ANGLE_W    = 32;
   localparam int SEL_W      = 2;
   localparam int ARG_SHIFT  = 30 - ARG_FRAC_BITS;
   localparam int XY_W       = ARG_W + ARG_SHIFT + 3;
   localparam int Z_W        = 34;
   localparam int MAG_W      = 31;
   localparam int RAD_W      = 62;
   localparam int REM_W      = 34;
   localparam int SQ_STEPS   = RAD_W / 2;
   localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
   localparam int IT_CNT_W   = $clog2(ITERATIONS);
   localparam int TAB_IDX_W  = 5;

   localparam logic [SEL_W-1:0] SEL_ASIN       = 2'd0;
   localparam logic [SEL_W-1:0] SEL_ACOS       = 2'd1;
   localparam logic [SEL_W-1:0] SEL_ATAN       = 2'd2;
   // The spare selector value also computes arctangent.
   localparam logic [SEL_W-1:0] SEL_ATAN_ALIAS = 2'd3;

   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   // round(atan(2^-i) * 2^30)
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         5'd24: v = 34'sd64;
         5'd25: v = 34'sd32;
         5'd26: v = 34'sd16;
         5'd27: v = 34'sd8;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         5'd30: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/itsu_sqrt.sv
// Digit-serial square root of 2^60 - m*m, two radicand bits per cycle.
module itsu_sqrt
   import itsu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] mag,
   output logic             done,
   output logic [MAG_W-1:0] root
);

   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic                mul_ff, mul_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]    root_ff, root_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]    rem_shift;
   logic [REM_W-1:0]    trial;
   logic [RAD_W-1:0]    square;

   assign square    = RAD_W'(mag_ff) * RAD_W'(mag_ff);
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = REM_W'({root_ff, 2'b01});

   always_comb begin
      mag_in  = mag_ff;
      mul_in  = 1'b0;
      run_in  = run_ff;
      done_in = 1'b0;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         mag_in = mag;
         mul_in = 1'b1;
      end else if (mul_ff) begin
         // The radicand never exceeds 2^60, so it fits with room for the top digit.
         rad_in  = (RAD_W'(1) << 60) - square;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in = rad_ff << 2;
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CNT_W'(SQ_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mag_ff  <= mag_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: rtl/core/itsu_cordic.sv
// CORDIC vectoring engine, one micro-rotation per cycle.
module itsu_cordic
   import itsu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [XY_W-1:0] x_start,
   input  logic signed [XY_W-1:0] y_start,
   output logic                   done,
   output logic signed [Z_W-1:0]  angle
);

   logic signed [XY_W-1:0] x_ff, x_in;
   logic signed [XY_W-1:0] y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic [IT_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  entry;

   assign xs    = x_ff >>> cnt_ff;
   assign ys    = y_ff >>> cnt_ff;
   assign entry = atan_entry(TAB_IDX_W'(cnt_ff));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = '0;
         run_in = 1'b1;
         if (x_start < 0) begin
            // Left half plane: turn the vector a quarter turn first.
            x_in = y_start;
            y_in = -x_start;
            z_in = HALF_PI_Q30;
         end else begin
            x_in = x_start;
            y_in = y_start;
            z_in = '0;
         end
      end else if (run_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + entry;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - entry;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == IT_CNT_W'(ITERATIONS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

FILE: rtl/core/inverse_trig_select_unit.sv
// Top level of the inverse trigonometric unit: control, domain check and result register.
//
// Each request carries one signed Q16.16 argument and returns one signed Q2.29 angle in
// radians, computed as arcsine, arccosine or arctangent according to csr_write_data last
// written (a value of three acts as arctangent). Requests are processed one at a time.
// Arcsine and arccosine first run a digit-serial square root that retires two radicand
// bits per cycle (a launch step, then a multiply step that also loads the radicand, then
// the root steps); the shared CORDIC engine then takes a load step and 28 micro-rotations
// at one per cycle, after which the rounded angle is written to the result register.
// Arctangent skips the square root and starts the CORDIC engine on acceptance.
// An arcsine or arccosine argument outside [-1,+1] goes from acceptance straight to the
// finish state and is answered with the last computed angle and rsp_in_domain low. The
// next request is accepted once the finish state has moved a result into the output
// register. The finished result sits in an output register, so the unit returns to idle
// while it waits to be taken; a stalled response only delays the following result once
// that one is finished.
module inverse_trig_select_unit
   import itsu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [SEL_W-1:0]         csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ARG_W-1:0]  req_argument,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ANGLE_W-1:0] rsp_angle,
   output logic                     rsp_in_domain
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQRT,
      ST_CORDIC,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [SEL_W-1:0]        sel_ff, sel_in;
   logic [SEL_W-1:0]        func_ff, func_in;
   logic signed [XY_W-1:0]  t_ff, t_in;
   logic signed [ANGLE_W-1:0] result_ff, result_in;
   logic                    dom_ff, dom_in;
   logic signed [ANGLE_W-1:0] held_angle_ff, held_angle_in;
   logic signed [ANGLE_W-1:0] out_angle_ff, out_angle_in;
   logic                    out_dom_ff, out_dom_in;
   logic                    out_valid_ff, out_valid_in;

   logic                    accept;
   logic                    trig_sel;
   logic                    out_of_range;
   logic signed [XY_W-1:0]  t_wide;
   logic [MAG_W-1:0]        t_mag;
   logic                    sqrt_start, sqrt_done;
   logic [MAG_W-1:0]        sqrt_root;
   logic                    cordic_start, cordic_done;
   logic signed [XY_W-1:0]  cx, cy, s_wide;
   logic signed [Z_W-1:0]   cordic_angle;
   logic signed [Z_W-1:0]   z_round;
   logic                    out_free;

   assign accept   = req_valid && !req_stall;
   assign trig_sel = (func_ff == SEL_ASIN) || (func_ff == SEL_ACOS);

   // The argument is widened to Q30; for the sine pair it must lie within one.
   assign t_wide       = XY_W'(req_argument) <<< ARG_SHIFT;
   assign out_of_range = (req_argument > ARG_W'(1 << ARG_FRAC_BITS)) ||
                         (req_argument < -ARG_W'(1 << ARG_FRAC_BITS));
   assign t_mag        = (t_ff < 0) ? MAG_W'(-t_ff) : MAG_W'(t_ff);
   assign s_wide       = XY_W'({1'b0, sqrt_root});
   assign z_round      = (cordic_angle + Z_W'(1)) >>> 1;
   assign out_free     = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      func_in       = func_ff;
      t_in          = t_ff;
      result_in     = result_ff;
      dom_in        = dom_ff;
      held_angle_in = held_angle_ff;
      out_angle_in  = out_angle_ff;
      out_dom_in    = out_dom_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      sqrt_start    = 1'b0;
      cordic_start  = 1'b0;
      cx            = XY_W'(1) <<< 30;
      cy            = t_ff;

      if (csr_write_enable) begin
         func_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sel_in = func_ff;
               t_in   = t_wide;
               if (trig_sel && out_of_range) begin
                  result_in = held_angle_ff;
                  dom_in    = 1'b0;
                  state_in  = ST_FINISH;
               end else if (trig_sel) begin
                  state_in = ST_SQRT;
               end else begin
                  cy           = t_wide;
                  cordic_start = 1'b1;
                  state_in     = ST_CORDIC;
               end
            end
         end
         ST_SQRT: begin
            // Launch comes from sqrt_go_ff, so t_ff already holds the argument.
            sqrt_start = 1'b0;
            if (sqrt_done) begin
               if (sel_ff == SEL_ASIN) begin
                  cx = s_wide;
                  cy = t_ff;
               end else begin
                  cx = t_ff;
                  cy = s_wide;
               end
               cordic_start = 1'b1;
               state_in     = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               result_in = ANGLE_W'(z_round);
               dom_in    = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_angle_in = result_ff;
               out_dom_in   = dom_ff;
               out_valid_in = 1'b1;
               if (dom_ff) begin
                  held_angle_in = result_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_ff == ST_IDLE && accept && trig_sel && !out_of_range) begin
         sqrt_start = 1'b0;
      end
   end

   // The square root starts on the first cycle in ST_SQRT from the stored argument.
   logic sqrt_go_ff, sqrt_go_in;
   assign sqrt_go_in = (state_ff == ST_IDLE) && (state_in == ST_SQRT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         func_ff       <= SEL_ASIN;
         held_angle_ff <= '0;
         out_valid_ff  <= 1'b0;
         sqrt_go_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         func_ff       <= func_in;
         held_angle_ff <= held_angle_in;
         out_valid_ff  <= out_valid_in;
         sqrt_go_ff    <= sqrt_go_in;
      end
      sel_ff       <= sel_in;
      t_ff         <= t_in;
      result_ff    <= result_in;
      dom_ff       <= dom_in;
      out_angle_ff <= out_angle_in;
      out_dom_ff   <= out_dom_in;
   end

   itsu_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_go_ff || sqrt_start),
      .mag   (t_mag),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   itsu_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .x_start (cx),
      .y_start (cy),
      .done    (cordic_done),
      .angle   (cordic_angle)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = out_valid_ff;
   assign rsp_angle     = out_angle_ff;
   assign rsp_in_domain = out_dom_ff;

   a_sqrt_done_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == ST_SQRT))
      else $error("square root finished outside its state");

   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == ST_CORDIC))
      else $error("CORDIC finished outside its state");

   a_held_matches: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dom_ff) |-> (held_angle_ff == out_angle_ff))
      else $error("held angle differs from the delivered in-domain angle");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> out_valid_ff)
      else $error("finished result was not registered");

endmodule

FILE: bench/tb_inverse_trig_select_unit.sv
// Self-checking testbench for the inverse trigonometric unit with a fixed-point angle predictor.
`timescale 1ns / 100ps

module tb_inverse_trig_select_unit;
   import itsu_pkg::*;

   // The angle predictor tracks the selected function and the last angle produced, and it
   // keeps the queue of angles that are still owed by the unit.
   class angle_scoreboard;
      logic [SEL_W-1:0]          func_sel;
      logic signed [ANGLE_W-1:0] last_angle;
      logic signed [ANGLE_W-1:0] pending_angle[$];
      logic                      pending_dom[$];
      int                        errors;

      function new();
         func_sel   = SEL_ASIN;
         last_angle = '0;
         errors     = 0;
      endfunction

      // Floor division by a power of two; the >>> operator on a signed value does this.
      static function longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      static function longint int_sqrt(longint unsigned v);
         longint unsigned root;
         longint unsigned bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v    = v - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      static function longint cordic_angle(longint x, longint y);
         longint z;
         longint tmp;
         longint xs;
         longint ys;
         z = 0;
         // A vector in the left half plane is turned a quarter first.
         if (x < 0) begin
            tmp = x;
            x   = y;
            y   = -tmp;
            z   = HALF_PI_Q30;
         end
         for (int i = 0; i < ITERATIONS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + longint'(atan_entry(i[TAB_IDX_W-1:0]));
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - longint'(atan_entry(i[TAB_IDX_W-1:0]));
            end
         end
         return z;
      endfunction

      // Notes an accepted request and queues the angle it must produce.
      function void note_request(logic signed [ARG_W-1:0] arg);
         longint a;
         longint t;
         longint s;
         longint z;
         longint unsigned mag;
         a = longint'(arg);
         if (func_sel < SEL_ATAN && (a < -(64'sd1 << ARG_FRAC_BITS) ||
                                     a > (64'sd1 << ARG_FRAC_BITS))) begin
            pending_angle.push_back(last_angle);
            pending_dom.push_back(1'b0);
            return;
         end
         t = a * (64'sd1 << ARG_SHIFT);
         if (func_sel < SEL_ATAN) begin
            mag = (t < 0) ? -t : t;
            s   = int_sqrt((64'd1 << 60) - mag * mag);
            z   = (func_sel == SEL_ASIN) ? cordic_angle(s, t) : cordic_angle(t, s);
         end else begin
            z = cordic_angle(64'sd1 << 30, t);
         end
         last_angle = ANGLE_W'(floor_shift(z + 1, 1));
         pending_angle.push_back(last_angle);
         pending_dom.push_back(1'b1);
      endfunction

      function void check_result(logic signed [ANGLE_W-1:0] angle, logic dom);
         logic signed [ANGLE_W-1:0] exp_angle;
         logic                      exp_dom;
         if (pending_angle.size() == 0) begin
            $display("%0t: unexpected response angle %0d in_domain %0b", $time, angle, dom);
            errors++;
            return;
         end
         exp_angle = pending_angle.pop_front();
         exp_dom   = pending_dom.pop_front();
         if (angle !== exp_angle) begin
            $display("%0t: angle mismatch expected %0d actual %0d", $time, exp_angle, angle);
            errors++;
         end
         if (dom !== exp_dom) begin
            $display("%0t: in_domain mismatch expected %0b actual %0b", $time, exp_dom, dom);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [SEL_W-1:0]          csr_write_data;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [ARG_W-1:0]   req_argument;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [ANGLE_W-1:0] rsp_angle;
   logic                      rsp_in_domain;

   angle_scoreboard board;
   bit              stall_enable;

   inverse_trig_select_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_argument     (req_argument),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_angle        (rsp_angle),
      .rsp_in_domain    (rsp_in_domain)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Responses are checked at the edge where they are taken; stall changes right after.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_angle, rsp_in_domain);
   end

   // The receiver stalls on its own pattern: calm stretches, light stalling and heavy stalling follow in turn.
   initial begin
      int phase;
      rsp_stall = 1'b0;
      phase     = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (!stall_enable) rsp_stall <= 1'b0;
         else if ((phase / 200) % 3 == 0) rsp_stall <= 1'b0;
         else if ((phase / 200) % 3 == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 3) != 0);
      end
   end

   // Sends one request and holds it until the unit takes it.
   task automatic send_request(logic signed [ARG_W-1:0] arg);
      req_valid    <= 1'b1;
      req_argument <= arg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(arg);
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // The register is only written once every owed response has been taken and the unit
   // has had time to settle.
   task automatic write_select(logic [SEL_W-1:0] value);
      idle_cycles(1);
      while (board.pending_angle.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.func_sel = value;
   endtask

   // Random argument: mostly inside [-1,+1], sometimes near the edges, sometimes anything.
   function automatic logic signed [ARG_W-1:0] random_argument();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return ARG_W'($signed($urandom_range(0, 131072)) - 65536);
      if (pick < 8) return ARG_W'($signed($urandom_range(0, 8)) + 65532) *
                           ($urandom_range(0, 1) ? 1 : -1);
      return $urandom;
   endfunction

   task automatic random_burst(int count);
      int left;
      left = count;
      while (left > 0) begin
         int burst;
         burst = $urandom_range(1, 8);
         for (int k = 0; k < burst && left > 0; k++) begin
            send_request(random_argument());
            left--;
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 40));
      end
   endtask

   initial begin
      logic signed [ARG_W-1:0] edge_args[$];
      logic [SEL_W-1:0]        sel_order[$];
      board            = new();
      stall_enable     = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = SEL_ASIN;
      req_valid        = 1'b0;
      req_argument     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: exact +1 and -1, zero, just outside the domain, extremes, +-1/2 and +-1 LSB.
      edge_args = '{32'sh0001_0000, -32'sh0001_0000, 32'sh0, 32'sh0001_0001,
                    -32'sh0001_0001, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_8000,
                    -32'sh0000_8000, 32'sh0000_0001, 32'shFFFF_FFFF};
      // Arcsine first on reset, then a rejected item before anything is computed.
      send_request(32'sh0002_0000);
      foreach (edge_args[i]) send_request(edge_args[i]);
      sel_order = '{SEL_ACOS, SEL_ATAN, SEL_ATAN_ALIAS};
      foreach (sel_order[j]) begin
         write_select(sel_order[j]);
         foreach (edge_args[i]) send_request(edge_args[i]);
      end

      // Random phases with both sides idling, the selector swept through every value.
      stall_enable = 1'b1;
      sel_order = '{SEL_ASIN, SEL_ATAN, SEL_ACOS, SEL_ATAN_ALIAS, SEL_ASIN, SEL_ACOS};
      foreach (sel_order[j]) begin
         write_select(sel_order[j]);
         random_burst(100);
      end

      idle_cycles(1);
      while (board.pending_angle.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) $display("PASS inverse_trig_select_unit");
      else $display("FAIL inverse_trig_select_unit");
      $finish;
   end

   // Generous bound for about 650 requests with stalls.
   initial begin
      #5_000_000;
      $display("FAIL inverse_trig_select_unit");
      $finish;
   end

endmodule
